// ----- hw/rtl/htfd_pkg.sv -----
`default_nettype none

package htfd_pkg;

  // CRC-8 as used by the sensor: x^8 + x^5 + x^4 + 1, preset all ones
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Fixed point conversion constants (Q16)
  localparam logic [7:0]  TEMP_SCALE      = 8'd175;
  localparam logic [24:0] TEMP_OFFSET_Q16 = 25'd2949120;  // 45 * 65536
  localparam logic [6:0]  HUM_SCALE       = 7'd100;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned TEMP_W = 25;
  localparam int unsigned HUM_W  = 23;

  // Byte positions within a six-byte frame
  typedef logic [2:0] pos_t;
  localparam pos_t POS_TEMP_HI  = 3'd0;
  localparam pos_t POS_TEMP_LO  = 3'd1;
  localparam pos_t POS_TEMP_CRC = 3'd2;
  localparam pos_t POS_HUM_HI   = 3'd3;
  localparam pos_t POS_HUM_LO   = 3'd4;
  localparam pos_t POS_HUM_CRC  = 3'd5;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_CRC = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/htfd_crc8.sv -----
`default_nettype none

module htfd_crc8
  import htfd_pkg::*;
(
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  output logic      [7:0] crc_out
);

  // Unrolled MSB-first update over one byte
  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/humidity_temp_frame_decoder.sv -----
`default_nettype none

// Channel   Dir  tdata (low bit up)                         tuser
// in_       in   [7:0] data_byte                            [0] frame_start
// out_      out  [24:0] temperature_q16, [47:25] humidity_q16  [0] status
//
// Two register stages: an input register, then the decode logic (CRC step,
// constant multiplies) into the result register, which is loaded as the
// sixth byte is decoded; one byte is taken every cycle unless the result stalls.
// Reset is synchronous, active low; the frame position restarts at byte 0.
// A stalled result holds both stages; the input register still refills as
// soon as its byte moves on, so no cycle is lost while out_tready is high.

module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [24:0] temperature_q16, [47:25] humidity_q16
  output logic             out_tuser   // [0] status
);

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;

  // Frame state
  pos_t              pos_r, pos_nxt;
  logic [7:0]        crc_r, crc_nxt;
  logic [WORD_W-1:0] temp_word_r, temp_word_nxt;
  logic [WORD_W-1:0] hum_word_r, hum_word_nxt;
  logic              failed_r, failed_nxt;

  // Result register
  logic              out_valid_r;
  logic [47:0]       out_data_r, out_data_nxt;
  logic              out_status_r, out_status_nxt;

  logic              advance;
  logic              frame_done;
  pos_t              pos_eff;
  logic [7:0]        crc_seed;
  logic [7:0]        crc_step;
  logic              bad;
  logic [23:0]       temp_prod;
  logic [TEMP_W-1:0] temp_q16;
  logic [HUM_W-1:0]  hum_q16;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

  // Realign on frame_start or an out-of-range position
  assign pos_eff = (s1_start_r || pos_r > POS_HUM_CRC) ? POS_TEMP_HI : pos_r;

  // Restart the CRC on the first byte of each word
  assign crc_seed = (pos_eff == POS_TEMP_HI || pos_eff == POS_HUM_HI) ? CRC_INIT : crc_r;

  htfd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data_in (s1_byte_r),
    .crc_out (crc_step)
  );

  // Conversions: 175*T - 45*65536 and 100*H
  assign temp_prod = 24'(temp_word_r) * 24'(TEMP_SCALE);
  assign temp_q16  = {1'b0, temp_prod} - TEMP_OFFSET_Q16;
  assign hum_q16   = HUM_W'(hum_word_r) * HUM_W'(HUM_SCALE);

  assign bad        = failed_r || (crc_r != s1_byte_r);
  assign frame_done = (pos_eff == POS_HUM_CRC);

  // Next frame state and result
  always_comb begin
    pos_nxt        = pos_t'(pos_eff + 3'd1);
    crc_nxt        = crc_r;
    temp_word_nxt  = temp_word_r;
    hum_word_nxt   = hum_word_r;
    failed_nxt     = failed_r;
    out_data_nxt   = {hum_q16, temp_q16};
    out_status_nxt = STATUS_OK;
    unique case (pos_eff)
      POS_TEMP_HI: begin
        failed_nxt    = 1'b0;
        temp_word_nxt = {s1_byte_r, 8'h00};
        crc_nxt       = crc_step;
      end
      POS_TEMP_LO: begin
        temp_word_nxt = {temp_word_r[15:8], s1_byte_r};
        crc_nxt       = crc_step;
      end
      POS_TEMP_CRC: begin
        if (crc_r != s1_byte_r) begin
          failed_nxt = 1'b1;
        end
        crc_nxt = CRC_INIT;
      end
      POS_HUM_HI: begin
        hum_word_nxt = {s1_byte_r, 8'h00};
        crc_nxt      = crc_step;
      end
      POS_HUM_LO: begin
        hum_word_nxt = {hum_word_r[15:8], s1_byte_r};
        crc_nxt      = crc_step;
      end
      default: begin
        crc_nxt    = CRC_INIT;
        pos_nxt    = POS_TEMP_HI;
        failed_nxt = 1'b0;
        if (bad) begin
          out_data_nxt   = '0;
          out_status_nxt = STATUS_BAD_CRC;
        end
      end
    endcase
  end

  // Input register: load on transfer, drop once the byte is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // Frame state: advance with each decoded byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_TEMP_HI;
      crc_r       <= CRC_INIT;
      temp_word_r <= '0;
      hum_word_r  <= '0;
      failed_r    <= 1'b0;
    end else if (advance) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      temp_word_r <= temp_word_nxt;
      hum_word_r  <= hum_word_nxt;
      failed_r    <= failed_nxt;
    end
  end

  // Result register: load at frame end, clear on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && frame_done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && frame_done) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

endmodule

`default_nettype wire
